[hw/rtl/c2p_pkg.sv]
package c2p_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int GUARD_BITS        = 16;
    localparam int MAX_STAGES        = 24;
    localparam int Z_WIDTH           = 32;

    localparam logic [Z_WIDTH-1:0] ATAN_TURNS [MAX_STAGES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [0:0] {
        CFG_ORIGIN_X = 1'b0,
        CFG_ORIGIN_Y = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic at_origin;
    } t_ctrl;

    // floor(sqrt(cordic gain squared)) in q30, evaluated at elaboration
    function automatic logic [63:0] gain_sqrt(input int stages);
        logic [63:0] p;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        p = 64'd1 << 61;
        for (int i = 1; i < stages; i++) begin
            p = p + (p >> (2 * i));
        end
        v = p;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 64'd0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (r == 64'd0) begin
            r = 64'd1;
        end
        return r;
    endfunction

endpackage

[hw/rtl/c2p_stage.sv]
module c2p_stage #(
    parameter int XW    = 44,
    parameter int STAGE = 0
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic signed [XW-1:0]    i_x,
    input  logic signed [XW-1:0]    i_y,
    input  logic [31:0]             i_z,
    input  c2p_pkg::t_ctrl          i_ctrl,
    output logic signed [XW-1:0]    o_x,
    output logic signed [XW-1:0]    o_y,
    output logic [31:0]             o_z,
    output c2p_pkg::t_ctrl          o_ctrl
);
    import c2p_pkg::*;

    logic signed [XW-1:0] w_xs;
    logic signed [XW-1:0] w_ys;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic [Z_WIDTH-1:0]   n_z;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic [Z_WIDTH-1:0]   r_z;
    t_ctrl                r_ctrl;

    assign w_xs = i_x >>> STAGE;
    assign w_ys = i_y >>> STAGE;

    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + w_ys;
            n_y = i_y - w_xs;
            n_z = i_z + ATAN_TURNS[STAGE];
        end else begin
            n_x = i_x - w_ys;
            n_y = i_y + w_xs;
            n_z = i_z - ATAN_TURNS[STAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_ctrl = r_ctrl;

endmodule

[hw/rtl/cartesian_to_polar_convert_top.sv]
// cartesian to polar converter, pipelined cordic in vectoring mode
// input channel: i_valid / o_ready with i_point_x, i_point_y (signed, 8 frac bits)
// output channel: o_valid / i_ready with o_radius (unsigned, 8 frac bits),
//   o_angle (binary angle, half scale is pi) and o_at_origin
// config: i_cfg_we writes i_cfg_data into origin_x or origin_y per i_cfg_idx,
//   taking effect for the next transaction accepted
// pipeline registers from input accept to o_valid:
//   difference, quarter-turn fold, a register per cordic iteration,
//   gain multiply, round and saturate, output register
// throughput: one transaction per cycle while the skid register is empty, set by the single iteration per stage
// reset: synchronous active low, clears all valid bits and both origin registers
// stall: the output register is backed by a one-entry skid register; the
//   pipeline keeps moving while only the output register is full and freezes
//   as a whole once the skid register holds a result, dropping o_ready
module cartesian_to_polar_convert_top #(
    parameter int COORD_WIDTH   = c2p_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH   = c2p_pkg::ANGLE_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  c2p_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_WIDTH:0]          o_radius,
    output logic signed [ANGLE_WIDTH-1:0] o_angle,
    output logic                          o_at_origin
);
    import c2p_pkg::*;

    localparam int DW     = COORD_WIDTH + 1;
    localparam int XW     = COORD_WIDTH + GUARD_BITS + 4;
    localparam int MW     = (XW - 1 > 32) ? XW - 1 : 33;
    localparam int QW     = MW + 1;
    localparam int SW     = QW + 1;
    localparam int RQW    = SW - GUARD_BITS;
    localparam int RW     = COORD_WIDTH + 1;
    localparam logic [63:0] GAIN_SQRT = gain_sqrt(CORDIC_STAGES);
    localparam logic [63:0] GAIN_K64  = ((64'd1 << 62) + GAIN_SQRT / 2) / GAIN_SQRT;
    localparam logic [31:0] GAIN_K    = GAIN_K64[31:0];

    logic pipe_en;

    // origin registers
    logic signed [COORD_WIDTH-1:0] r_origin_x;
    logic signed [COORD_WIDTH-1:0] r_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // difference stage
    logic signed [DW-1:0] r_dx;
    logic signed [DW-1:0] r_dy;
    logic                 r_d_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (pipe_en) begin
            r_d_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dx <= DW'(i_point_x) - DW'(r_origin_x);
            r_dy <= DW'(i_point_y) - DW'(r_origin_y);
        end
    end

    // quarter-turn fold into the right half plane, guard bits added
    logic signed [XW-1:0]  w_dx;
    logic signed [XW-1:0]  w_dy;
    logic signed [XW-1:0]  n_fx;
    logic signed [XW-1:0]  n_fy;
    logic [Z_WIDTH-1:0]    n_fz;
    t_ctrl                 n_fctrl;
    logic signed [XW-1:0]  r_fx;
    logic signed [XW-1:0]  r_fy;
    logic [Z_WIDTH-1:0]    r_fz;
    t_ctrl                 r_fctrl;

    assign w_dx = XW'(r_dx);
    assign w_dy = XW'(r_dy);

    always_comb begin
        if (w_dx[XW-1]) begin
            if (!w_dy[XW-1]) begin
                n_fx = w_dy <<< GUARD_BITS;
                n_fy = (-w_dx) <<< GUARD_BITS;
                n_fz = Z_WIDTH'(1) << (Z_WIDTH - 2);
            end else begin
                n_fx = (-w_dy) <<< GUARD_BITS;
                n_fy = w_dx <<< GUARD_BITS;
                n_fz = Z_WIDTH'(0) - (Z_WIDTH'(1) << (Z_WIDTH - 2));
            end
        end else begin
            n_fx = w_dx <<< GUARD_BITS;
            n_fy = w_dy <<< GUARD_BITS;
            n_fz = '0;
        end
        n_fctrl.valid     = r_d_v;
        n_fctrl.at_origin = (r_dx == '0) && (r_dy == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fctrl <= '0;
        end else if (pipe_en) begin
            r_fctrl <= n_fctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_fx <= n_fx;
            r_fy <= n_fy;
            r_fz <= n_fz;
        end
    end

    // cordic iterations, one per stage
    logic signed [XW-1:0] w_x    [CORDIC_STAGES+1];
    logic signed [XW-1:0] w_y    [CORDIC_STAGES+1];
    logic [Z_WIDTH-1:0]   w_z    [CORDIC_STAGES+1];
    t_ctrl                w_ctrl [CORDIC_STAGES+1];

    assign w_x[0]    = r_fx;
    assign w_y[0]    = r_fy;
    assign w_z[0]    = r_fz;
    assign w_ctrl[0] = r_fctrl;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_iter
        c2p_stage #(
            .XW    (XW),
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_ctrl  (w_ctrl[g]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_ctrl  (w_ctrl[g+1])
        );
    end

    // gain multiply, split into low and high partial products
    logic signed [XW-1:0] w_xf;
    logic [XW-2:0]        w_xpos;
    logic [MW-1:0]        w_xm;
    logic [MW-33:0]       w_xhi;
    logic [31:0]          w_xlo;
    logic [MW-1:0]        n_mhi;
    logic [63:0]          n_mlo;
    logic [MW-1:0]        r_mhi;
    logic [63:0]          r_mlo;
    logic [Z_WIDTH-1:0]   r_mz;
    t_ctrl                r_mctrl;

    assign w_xf   = w_x[CORDIC_STAGES];
    assign w_xpos = w_xf[XW-1] ? '0 : w_xf[XW-2:0];
    assign w_xm   = MW'(w_xpos);
    assign w_xhi  = w_xm[MW-1:32];
    assign w_xlo  = w_xm[31:0];
    assign n_mhi  = w_xhi * GAIN_K;
    assign n_mlo  = w_xlo * GAIN_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mctrl <= '0;
        end else if (pipe_en) begin
            r_mctrl <= w_ctrl[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_mhi <= n_mhi;
            r_mlo <= n_mlo;
            r_mz  <= w_z[CORDIC_STAGES];
        end
    end

    // round, saturate, angle quantize, zero radius and angle at the origin
    logic [QW-1:0]          w_q;
    logic [SW-1:0]          w_sum;
    logic [RQW-1:0]         w_rq;
    logic                   w_sat;
    logic [Z_WIDTH-1:0]     w_zr;
    logic [RW-1:0]          n_rad;
    logic [ANGLE_WIDTH-1:0] n_ang;
    logic [RW-1:0]          r_rad;
    logic [ANGLE_WIDTH-1:0] r_ang;
    t_ctrl                  r_rctrl;

    assign w_q   = QW'(r_mhi) + QW'(r_mlo[63:32]);
    assign w_sum = SW'(w_q) + (SW'(1) << (GUARD_BITS - 1));
    assign w_rq  = w_sum[SW-1:GUARD_BITS];
    assign w_sat = |w_rq[RQW-1:RW];
    assign w_zr  = r_mz + (Z_WIDTH'(1) << (Z_WIDTH - 1 - ANGLE_WIDTH));

    always_comb begin
        if (r_mctrl.at_origin) begin
            n_rad = '0;
            n_ang = '0;
        end else begin
            n_rad = w_sat ? '1 : w_rq[RW-1:0];
            n_ang = w_zr[Z_WIDTH-1 -: ANGLE_WIDTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rctrl <= '0;
        end else if (pipe_en) begin
            r_rctrl <= r_mctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_rad <= n_rad;
            r_ang <= n_ang;
        end
    end

    // output register with skid register
    logic                   r_out_v;
    logic [RW-1:0]          r_out_rad;
    logic [ANGLE_WIDTH-1:0] r_out_ang;
    logic                   r_out_org;
    logic                   r_skid_v;
    logic [RW-1:0]          r_skid_rad;
    logic [ANGLE_WIDTH-1:0] r_skid_ang;
    logic                   r_skid_org;
    logic                   w_out_free;

    assign pipe_en    = !r_skid_v;
    assign w_out_free = !r_out_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_rctrl.valid;
            end
        end else if (r_rctrl.valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_v) begin
                r_out_rad <= r_skid_rad;
                r_out_ang <= r_skid_ang;
                r_out_org <= r_skid_org;
            end else begin
                r_out_rad <= r_rad;
                r_out_ang <= r_ang;
                r_out_org <= r_rctrl.at_origin;
            end
        end else if (!r_skid_v) begin
            r_skid_rad <= r_rad;
            r_skid_ang <= r_ang;
            r_skid_org <= r_rctrl.at_origin;
        end
    end

    assign o_ready     = pipe_en;
    assign o_valid     = r_out_v;
    assign o_radius    = r_out_rad;
    assign o_angle     = r_out_ang;
    assign o_at_origin = r_out_org;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while output register is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v) && !$past(i_ready))
        else $error("skid register filled without an output stall");

    a_origin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_at_origin) |-> (o_radius == '0) && (o_angle == '0))
        else $error("origin transaction with nonzero radius or angle");

endmodule

[verif/tb_cartesian_to_polar_convert_top.sv]
`timescale 1ns / 100ps

module tb_cartesian_to_polar_convert_top;

    localparam int CW = c2p_pkg::COORD_WIDTH_DEF;
    localparam int AW = c2p_pkg::ANGLE_WIDTH_DEF;
    localparam int STAGES = c2p_pkg::CORDIC_STAGES_DEF;
    localparam int SCALE_BITS = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = STAGES + 12;
    localparam int RANDOM_SEGMENTS = 8;
    localparam int SEGMENT_POINTS = 132;

    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};

    // atan(2^-i) as a fraction of a full turn, 32-bit
    localparam bit [31:0] TURN_STEP [0:15] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } t_point;

    typedef struct packed {
        logic [CW:0]          radius;
        logic signed [AW-1:0] angle;
        logic                 at_origin;
    } t_polar;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    c2p_pkg::t_cfg_idx    i_cfg_idx = c2p_pkg::CFG_ORIGIN_X;
    logic [CW-1:0]        i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [CW-1:0] i_point_x = '0;
    logic signed [CW-1:0] i_point_y = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [CW:0]          o_radius;
    logic signed [AW-1:0] o_angle;
    logic                 o_at_origin;

    logic signed [CW-1:0] origin_x_q = '0;
    logic signed [CW-1:0] origin_y_q = '0;
    bit [63:0]            gain_inv;

    t_point point_queue[$];
    t_polar expected_polar[$];
    t_point next_point;
    t_polar want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int points_sent = 0;
    int results_seen = 0;
    int origin_hits = 0;
    int mismatches = 0;
    int origin_settings = 0;
    int idle_cycles = 0;

    cartesian_to_polar_convert_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_radius    (o_radius),
        .o_angle     (o_angle),
        .o_at_origin (o_at_origin)
    );

    always #2 i_clk = ~i_clk;

    // reciprocal of the cordic gain, q32
    function automatic bit [63:0] inverse_gain();
        bit [63:0] p;
        bit [63:0] v;
        bit [63:0] r;
        bit [63:0] b;
        p = 64'd1 << 61;
        for (int i = 1; i < STAGES; i++) begin
            p = p + (p >> (2 * i));
        end
        v = p;
        r = '0;
        b = 64'd1 << 62;
        while (b > v) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (r == 0) begin
            r = 64'd1;
        end
        return ((64'd1 << 62) + r / 2) / r;
    endfunction

    function automatic t_polar polar_of(input logic signed [CW-1:0] px,
                                        input logic signed [CW-1:0] py);
        t_polar    res;
        longint    dx;
        longint    dy;
        longint    xa;
        longint    ya;
        longint    xs;
        longint    ys;
        bit [31:0] z;
        bit [31:0] zr;
        bit [63:0] mag;
        bit [63:0] prod;
        res = '0;
        dx = longint'(px) - longint'(origin_x_q);
        dy = longint'(py) - longint'(origin_y_q);
        if (dx == 0 && dy == 0) begin
            res.at_origin = 1'b1;
            return res;
        end
        z = '0;
        // fold the left half plane by a quarter turn
        if (dx < 0) begin
            if (dy >= 0) begin
                xa = dy;
                ya = -dx;
                z = 32'h4000_0000;
            end else begin
                xa = -dy;
                ya = dx;
                z = 32'hC000_0000;
            end
        end else begin
            xa = dx;
            ya = dy;
        end
        xa = xa * (longint'(1) << SCALE_BITS);
        ya = ya * (longint'(1) << SCALE_BITS);
        for (int i = 0; i < STAGES; i++) begin
            xs = xa >>> i;
            ys = ya >>> i;
            if (ya >= 0) begin
                xa = xa + ys;
                ya = ya - xs;
                z = z + TURN_STEP[i];
            end else begin
                xa = xa - ys;
                ya = ya + xs;
                z = z - TURN_STEP[i];
            end
        end
        if (xa < 0) begin
            xa = 0;
        end
        mag = xa;
        prod = (mag >> 32) * gain_inv + (((mag & 64'hFFFF_FFFF) * gain_inv) >> 32);
        prod = (prod + (64'd1 << (SCALE_BITS - 1))) >> SCALE_BITS;
        if (prod >= (64'd1 << (CW + 1))) begin
            res.radius = '1;
        end else begin
            res.radius = prod[CW:0];
        end
        zr = z + (32'd1 << (31 - AW));
        res.angle = zr[31 -: AW];
        return res;
    endfunction

    function automatic logic signed [CW-1:0] extreme_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return '1;
            default: return CW'($urandom);
        endcase
    endfunction

    task automatic add_point(input logic signed [CW-1:0] px, input logic signed [CW-1:0] py);
        point_queue.push_back('{x: px, y: py});
    endtask

    task automatic wait_idle();
        while (!(point_queue.size() == 0 && !i_valid && expected_polar.size() == 0)) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_origin(input logic signed [CW-1:0] ox, input logic signed [CW-1:0] oy);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= c2p_pkg::CFG_ORIGIN_X;
        i_cfg_data <= ox;
        @(posedge i_clk);
        i_cfg_idx <= c2p_pkg::CFG_ORIGIN_Y;
        i_cfg_data <= oy;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        origin_x_q = ox;
        origin_y_q = oy;
        origin_settings++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_polar.push_back(polar_of(i_point_x, i_point_y));
                points_sent++;
            end
            if (!i_valid || o_ready) begin
                if (point_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_point = point_queue.pop_front();
                    i_valid <= 1'b1;
                    i_point_x <= next_point.x;
                    i_point_y <= next_point.y;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_polar.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result with no transaction pending: radius %0d angle %0d flag %0b",
                                 o_radius, o_angle, o_at_origin);
                    end
                end else begin
                    want = expected_polar.pop_front();
                    results_seen++;
                    if (want.at_origin) begin
                        origin_hits++;
                    end
                    if (o_radius !== want.radius || o_angle !== want.angle ||
                        o_at_origin !== want.at_origin) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch at %0t: expected radius %0d angle %0d flag %0b, got radius %0d angle %0d flag %0b",
                                     $realtime, want.radius, want.angle, want.at_origin,
                                     o_radius, o_angle, o_at_origin);
                        end
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_cartesian_to_polar_convert_top: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        gain_inv = inverse_gain();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // origin at zero
        write_origin('0, '0);
        add_point(0, 0);
        add_point(1, 0);
        add_point(0, 1);
        add_point(-1, 0);
        add_point(0, -1);
        add_point(COORD_MAX, COORD_MAX);
        add_point(COORD_MIN, COORD_MIN);
        add_point(COORD_MIN, 0);
        add_point(COORD_MAX, COORD_MIN);
        add_point(COORD_MIN, COORD_MAX);
        add_point(-256, 256);
        add_point(-256, -256);
        add_point(3, -5);
        wait_idle();

        // origin in the corners, largest distances
        write_origin(COORD_MAX, COORD_MIN);
        add_point(COORD_MIN, COORD_MAX);
        add_point(COORD_MAX, COORD_MIN);
        add_point(COORD_MAX, COORD_MAX);
        add_point(COORD_MIN, COORD_MIN);
        add_point(0, 0);
        wait_idle();
        write_origin(COORD_MIN, COORD_MAX);
        add_point(COORD_MAX, COORD_MIN);
        add_point(COORD_MIN, COORD_MAX);
        add_point(COORD_MAX, COORD_MAX);
        add_point(COORD_MIN, COORD_MIN);
        wait_idle();

        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            case (seg)
                0: write_origin('0, '0);
                1: write_origin(COORD_MAX, COORD_MIN);
                2: write_origin(COORD_MIN, COORD_MAX);
                3: write_origin(COORD_MAX, COORD_MAX);
                default: write_origin(CW'($urandom), CW'($urandom));
            endcase
            case (seg % 4)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct = 12;
                    recv_stall_pct = 12;
                end
            endcase
            for (int n = 0; n < SEGMENT_POINTS; n++) begin
                case ($urandom_range(0, 9))
                    5, 6: begin
                        // close to the origin
                        px = origin_x_q + CW'($urandom_range(0, 2048)) - CW'(1024);
                        py = origin_y_q + CW'($urandom_range(0, 2048)) - CW'(1024);
                    end
                    7: begin
                        px = origin_x_q;
                        py = origin_y_q;
                    end
                    8: begin
                        if ($urandom_range(0, 1)) begin
                            px = origin_x_q;
                            py = CW'($urandom);
                        end else begin
                            px = CW'($urandom);
                            py = origin_y_q;
                        end
                    end
                    9: begin
                        px = extreme_coord();
                        py = extreme_coord();
                    end
                    default: begin
                        px = CW'($urandom);
                        py = CW'($urandom);
                    end
                endcase
                add_point(px, py);
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d points over %0d origin settings under four traffic patterns",
                 points_sent, origin_settings);
        $display("checked %0d results, %0d on the origin, %0d mismatches",
                 results_seen, origin_hits, mismatches);
        if (mismatches == 0 && expected_polar.size() == 0) begin
            $display("tb_cartesian_to_polar_convert_top: PASS");
        end else begin
            $display("tb_cartesian_to_polar_convert_top: FAIL");
        end
        $finish;
    end

endmodule
